### rtl/core/soac_pkg.sv
// Package for the sensor offset auto-calibration core.
// Holds the status and opcode types, register indexes, constants and the structs
// shared by the core and its step logic. No dependencies.
package soac_pkg;

   localparam int AXIS_COUNT = 6;
   localparam int AXIS_AZ = 2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RUN  = 2'd1,
      ST_DONE = 2'd2,
      ST_FAIL = 2'd3
   } cal_status_type;

   typedef enum logic {
      OP_START  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_RANGE  = 2'd0;
   localparam logic [1:0] REG_LIMIT  = 2'd1;
   localparam logic [1:0] REG_TARGET = 2'd2;

   localparam logic [14:0] ONE_G_BASE   = 15'd16384;
   localparam logic [16:0] TRUNC_BIAS   = 17'd63;
   localparam logic [14:0] ERR_MAX      = 15'd32767;
   localparam logic [15:0] LIMIT_RESET  = 16'd100;
   localparam logic [14:0] TARGET_RESET = 15'd8;

   typedef logic [15:0] word16_type;

   typedef struct packed {
      logic [1:0]  range_shift;
      logic [15:0] limit;
      logic [14:0] target;
   } cal_cfg_type;

   // Axis order: accel X, Y, Z, gyro X, Y, Z.
   typedef struct packed {
      op_type                      op;
      word16_type [AXIS_COUNT-1:0] axis;
   } cal_item_type;

   typedef struct packed {
      word16_type [AXIS_COUNT-1:0] offset;
      logic [15:0]                 count;
      cal_status_type              status;
      logic [14:0]                 last_error;
   } cal_state_type;

endpackage

### rtl/core/soac_req_if.sv
// Request channel of the offset auto-calibration core: valid/ready plus one
// command word (opcode and six raw sensor readings). No dependencies.
interface soac_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;

   modport source(output valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
   modport sink(input valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                output ready);
endinterface

### rtl/core/soac_rsp_if.sv
// Response channel of the offset auto-calibration core: valid/ready plus one
// result word (six offsets, error, sample count, status). No dependencies.
interface soac_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] offset_ax;
   logic signed [15:0] offset_ay;
   logic signed [15:0] offset_az;
   logic signed [15:0] offset_gx;
   logic signed [15:0] offset_gy;
   logic signed [15:0] offset_gz;
   logic [14:0]        peak_error;
   logic [15:0]        iterations_done;
   logic [1:0]         cal_status;

   modport source(output valid, offset_ax, offset_ay, offset_az, offset_gx, offset_gy,
                  offset_gz, peak_error, iterations_done, cal_status, input ready);
   modport sink(input valid, offset_ax, offset_ay, offset_az, offset_gx, offset_gy,
                offset_gz, peak_error, iterations_done, cal_status, output ready);
endinterface

### rtl/core/soac_step.sv
// Next-state logic of the offset auto-calibration core for one command word.
// Depends on soac_pkg.
module soac_step (
   input  soac_pkg::cal_cfg_type   cfg,
   input  soac_pkg::cal_state_type state,
   input  soac_pkg::cal_item_type  item,
   output soac_pkg::cal_state_type state_next
);
   import soac_pkg::*;

   logic signed [16:0] axis_val [AXIS_COUNT];
   logic signed [16:0] quot     [AXIS_COUNT];
   logic        [16:0] mag      [AXIS_COUNT];
   logic        [16:0] one_g;
   logic        [16:0] worst;
   logic        [14:0] err_sat;
   logic        [15:0] count_next;
   word16_type  [AXIS_COUNT-1:0] offset_upd;

   assign one_g = {2'b00, ONE_G_BASE >> cfg.range_shift};

   always_comb begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
         axis_val[i] = $signed({item.axis[i][15], item.axis[i]});
      end
      axis_val[AXIS_AZ] = $signed({item.axis[AXIS_AZ][15], item.axis[AXIS_AZ]})
                          - $signed(one_g);

      worst = '0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         // Division by 64 truncating toward zero: bias negative values first.
         quot[i] = axis_val[i][16] ? ((axis_val[i] + $signed(TRUNC_BIAS)) >>> 6)
                                   : (axis_val[i] >>> 6);
         offset_upd[i] = item.axis[i] - item.axis[i] + state.offset[i] - quot[i][15:0];
         mag[i] = axis_val[i][16] ? 17'(-axis_val[i]) : 17'(axis_val[i]);
         if (mag[i] > worst) begin
            worst = mag[i];
         end
      end
      err_sat = (worst > {2'b00, ERR_MAX}) ? ERR_MAX : worst[14:0];
   end

   assign count_next = state.count + 16'd1;

   always_comb begin
      state_next = state;
      if (item.op == OP_START) begin
         state_next.offset     = '0;
         state_next.count      = '0;
         state_next.last_error = '0;
         state_next.status     = (cfg.limit == '0) ? ST_FAIL : ST_RUN;
      end else if (state.status == ST_RUN) begin
         state_next.offset     = offset_upd;
         state_next.count      = count_next;
         state_next.last_error = err_sat;
         if (err_sat < cfg.target) begin
            state_next.status = ST_DONE;
         end else if (count_next >= cfg.limit) begin
            state_next.status = ST_FAIL;
         end
      end
   end

endmodule

### rtl/core/sensor_offset_autocalibration_core.sv
// Top level of the six-axis offset auto-calibration core: APB register bank,
// input register, calibration state / result register. Depends on soac_pkg,
// soac_req_if, soac_rsp_if and soac_step.
//
//   channel   direction  handshake            word
//   req_chan  in         valid/ready          op + six raw readings
//   rsp_chan  out        valid/ready          six offsets, error, count, status
//   csr       in         psel/penable/pwrite  range shift, limit, target
//
// A word passes the input register, then the state register; one word per cycle
// is sustained while the response is taken, the step logic being combinational.
// The calibration state is also the response register, so it advances only
// when the response slot is free; a stalled response is held while one more
// request word waits in the input register. Reset is synchronous and clears
// the valid flags and the calibration state and loads the register reset values.
module sensor_offset_autocalibration_core (
   input  logic        clock,
   input  logic        reset,
   soac_req_if.sink    req_chan,
   soac_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import soac_pkg::*;

   cal_cfg_type   cfg_ff;
   cal_item_type  req_item_ff;
   logic          req_valid_ff;
   cal_state_type state_ff;
   cal_state_type state_in;
   logic          rsp_valid_ff;
   logic          advance;
   logic          cfg_write;
   cal_item_type  req_item;

   // Register bank.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_shift <= '0;
         cfg_ff.limit       <= LIMIT_RESET;
         cfg_ff.target      <= TARGET_RESET;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_RANGE:  cfg_ff.range_shift <= pwdata[1:0];
            REG_LIMIT:  cfg_ff.limit       <= pwdata[15:0];
            REG_TARGET: cfg_ff.target      <= pwdata[14:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_RANGE:  prdata = {30'd0, cfg_ff.range_shift};
         REG_LIMIT:  prdata = {16'd0, cfg_ff.limit};
         REG_TARGET: prdata = {17'd0, cfg_ff.target};
         default:    prdata = '0;
      endcase
   end

   // Input register.
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;

   assign req_item.op      = op_type'(req_chan.op);
   assign req_item.axis[0] = req_chan.accel_x;
   assign req_item.axis[1] = req_chan.accel_y;
   assign req_item.axis[2] = req_chan.accel_z;
   assign req_item.axis[3] = req_chan.gyro_x;
   assign req_item.axis[4] = req_chan.gyro_y;
   assign req_item.axis[5] = req_chan.gyro_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_item_ff <= req_item;
      end
   end

   soac_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (req_item_ff),
      .state_next (state_in)
   );

   // Calibration state doubles as the response word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.offset_ax       = state_ff.offset[0];
   assign rsp_chan.offset_ay       = state_ff.offset[1];
   assign rsp_chan.offset_az       = state_ff.offset[2];
   assign rsp_chan.offset_gx       = state_ff.offset[3];
   assign rsp_chan.offset_gy       = state_ff.offset[4];
   assign rsp_chan.offset_gz       = state_ff.offset[5];
   assign rsp_chan.peak_error      = state_ff.last_error;
   assign rsp_chan.iterations_done = state_ff.count;
   assign rsp_chan.cal_status      = state_ff.status;

   // A start word always leaves a cleared count and error.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      advance && req_item_ff.op == OP_START |=> state_ff.count == '0 && state_ff.last_error == '0)
      else $error("start did not clear count and error");

   // State moves only when a word passes into the response register.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("calibration state changed without a word");

   // The sample count either steps by one or restarts at zero.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(state_ff.count) |->
         state_ff.count == $past(state_ff.count) + 16'd1 || state_ff.count == '0)
      else $error("sample count jumped");

   // Before any start the calibrator has processed no samples.
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.status == ST_IDLE |-> state_ff.count == '0 && state_ff.offset == '0)
      else $error("idle state with nonzero count or offsets");

endmodule

### tb/tb_sensor_offset_autocalibration_core.sv
// Self-checking testbench for the six-axis offset auto-calibration core: directed and
// random request words, a per-word predictor and an in-order check of every response.
// Depends on soac_pkg, soac_req_if, soac_rsp_if and sensor_offset_autocalibration_core.
module tb_sensor_offset_autocalibration_core;
   import soac_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   soac_req_if req_chan();
   soac_rsp_if rsp_chan();

   sensor_offset_autocalibration_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   string offset_names [AXIS_COUNT] = '{"offset_ax", "offset_ay", "offset_az",
                                        "offset_gx", "offset_gy", "offset_gz"};

   cal_cfg_type   cal_cfg;
   cal_state_type cal_model;
   cal_state_type expected_reports [$];

   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int processed_items = 0;
   int mismatch_count  = 0;
   int cycle_count     = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Applies one accepted word to the calibration state. Returns 0 when the word
   // is a sample that the calibrator ignores.
   function automatic bit advance_calibration(input cal_item_type word);
      int diff [AXIS_COUNT];
      int one_g;
      int worst;
      int quotient;
      int magnitude;
      if (word.op == OP_START) begin
         cal_model.offset     = '0;
         cal_model.count      = '0;
         cal_model.last_error = '0;
         cal_model.status     = (cal_cfg.limit == 0) ? ST_FAIL : ST_RUN;
         return 1'b1;
      end
      if (cal_model.status != ST_RUN) return 1'b0;
      one_g = int'(ONE_G_BASE) >> cal_cfg.range_shift;
      for (int i = 0; i < AXIS_COUNT; i++) diff[i] = int'($signed(word.axis[i]));
      // The one-g level comes off Z at full precision, before the divide.
      diff[AXIS_AZ] -= one_g;
      cal_model.count = cal_model.count + 16'd1;
      worst = 0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         quotient = diff[i] / 64;
         cal_model.offset[i] = cal_model.offset[i] - quotient[15:0];
         magnitude = (diff[i] < 0) ? -diff[i] : diff[i];
         if (magnitude > worst) worst = magnitude;
      end
      if (worst > int'(ERR_MAX)) worst = int'(ERR_MAX);
      cal_model.last_error = worst[14:0];
      if (cal_model.last_error < cal_cfg.target) cal_model.status = ST_DONE;
      else if (cal_model.count >= cal_cfg.limit) cal_model.status = ST_FAIL;
      return 1'b1;
   endfunction

   function automatic cal_item_type start_word();
      cal_item_type word;
      word.op = OP_START;
      for (int i = 0; i < AXIS_COUNT; i++) word.axis[i] = 16'($urandom);
      return word;
   endfunction

   function automatic cal_item_type constant_word(input logic [15:0] pattern);
      cal_item_type word;
      word.op   = OP_SAMPLE;
      word.axis = {AXIS_COUNT{pattern}};
      return word;
   endfunction

   // A negative spread gives raw random readings; otherwise each axis sits within
   // the spread of its rest level (zero, or one g on accel Z).
   function automatic cal_item_type sensor_word(input int spread);
      cal_item_type word;
      int reading;
      word.op = OP_SAMPLE;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         if (spread < 0) begin
            word.axis[i] = 16'($urandom);
         end else begin
            reading = int'($urandom_range(2 * spread)) - spread;
            if (i == AXIS_AZ) reading += int'(ONE_G_BASE) >> cal_cfg.range_shift;
            word.axis[i] = reading[15:0];
         end
      end
      return word;
   endfunction

   task automatic send_word(input cal_item_type word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.op      <= word.op;
      req_chan.accel_x <= word.axis[0];
      req_chan.accel_y <= word.axis[1];
      req_chan.accel_z <= word.axis[AXIS_AZ];
      req_chan.gyro_x  <= word.axis[3];
      req_chan.gyro_y  <= word.axis[4];
      req_chan.gyro_z  <= word.axis[5];
      do @(posedge clock); while (!req_chan.ready);
      if (advance_calibration(word)) processed_items++;
      expected_reports.push_back(cal_model);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_RANGE:  cal_cfg.range_shift = value[1:0];
         REG_LIMIT:  cal_cfg.limit       = value;
         REG_TARGET: cal_cfg.target      = value[14:0];
         default: ;
      endcase
   endtask

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      cal_state_type seen;
      cal_state_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.offset[0]       = rsp_chan.offset_ax;
         seen.offset[1]       = rsp_chan.offset_ay;
         seen.offset[AXIS_AZ] = rsp_chan.offset_az;
         seen.offset[3]       = rsp_chan.offset_gx;
         seen.offset[4]       = rsp_chan.offset_gy;
         seen.offset[5]       = rsp_chan.offset_gz;
         if (expected_reports.size() == 0) begin
            $error("response word with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            for (int i = 0; i < AXIS_COUNT; i++) begin
               compare_field(offset_names[i], $signed(want.offset[i]), $signed(seen.offset[i]));
            end
            compare_field("peak_error", want.last_error, rsp_chan.peak_error);
            compare_field("iterations_done", want.count, rsp_chan.iterations_done);
            compare_field("cal_status", want.status, rsp_chan.cal_status);
         end
      end
   end

   task automatic test_sample_while_idle();
      send_word(sensor_word(-1));
   endtask

   task automatic test_reading_extremes();
      wait_drained();
      send_word(start_word());
      send_word(constant_word(16'h7FFF));
      send_word(constant_word(16'h8000));
      send_word(constant_word(16'h0000));
      send_word(constant_word(16'h5555));
      send_word(constant_word(16'hAAAA));
      send_word(constant_word(16'hFFFF));
   endtask

   // Readings exactly at rest converge on the first sample for every range.
   task automatic test_exact_level();
      for (int shift = 0; shift < 4; shift++) begin
         wait_drained();
         write_register(REG_RANGE, 16'(shift));
         send_word(start_word());
         send_word(sensor_word(0));
      end
      send_word(sensor_word(0));
   endtask

   task automatic test_zero_limit();
      wait_drained();
      write_register(REG_LIMIT, 16'd0);
      send_word(start_word());
      send_word(sensor_word(0));
   endtask

   // With a zero target even perfect samples run into the limit.
   task automatic test_zero_target();
      wait_drained();
      write_register(REG_TARGET, 16'd0);
      write_register(REG_LIMIT, 16'd2);
      send_word(start_word());
      repeat (3) send_word(sensor_word(0));
   endtask

   task automatic test_limit_lowered();
      wait_drained();
      write_register(REG_TARGET, 16'd8);
      write_register(REG_LIMIT, 16'd100);
      send_word(start_word());
      send_word(constant_word(16'h1000));
      send_word(constant_word(16'hF000));
      wait_drained();
      write_register(REG_LIMIT, 16'd1);
      send_word(constant_word(16'h1000));
   endtask

   task automatic randomize_registers();
      int pick;
      wait_drained();
      if ($urandom_range(1)) write_register(REG_RANGE, 16'($urandom_range(3)));
      if ($urandom_range(1)) begin
         pick = $urandom_range(9);
         case (pick)
            0:       write_register(REG_LIMIT, 16'd0);
            1:       write_register(REG_LIMIT, 16'hFFFF);
            2:       write_register(REG_LIMIT, 16'($urandom));
            default: write_register(REG_LIMIT, 16'($urandom_range(1, 40)));
         endcase
      end
      if ($urandom_range(1)) begin
         pick = $urandom_range(9);
         case (pick)
            0:       write_register(REG_TARGET, 16'd0);
            1:       write_register(REG_TARGET, 16'(ERR_MAX));
            2:       write_register(REG_TARGET, 16'($urandom_range(32767)));
            default: write_register(REG_TARGET, 16'($urandom_range(1, 64)));
         endcase
      end
   endtask

   // Mostly complete calibration runs whose sample spread decides whether they
   // converge or fail, mixed with stray samples and restarts in mid-run.
   task automatic test_random_runs(input int idle_pct, input int stall, input int quota);
      int spreads [6] = '{-1, 4000, 300, 40, 8, 2};
      int first;
      int spread;
      int length;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      first         = processed_items;
      while (processed_items - first < quota) begin
         if ($urandom_range(1)) randomize_registers();
         if ($urandom_range(9) == 0) send_word(sensor_word(-1));
         send_word(start_word());
         spread = spreads[$urandom_range(5)];
         length = $urandom_range(1, 40);
         for (int k = 0; k < length; k++) begin
            if (cal_model.status != ST_RUN) begin
               if ($urandom_range(9) < 3) send_word(sensor_word(spread));
               break;
            end
            if ($urandom_range(99) < 3) send_word(start_word());
            else if ($urandom_range(9) == 0) send_word(sensor_word(-1));
            else send_word(sensor_word(spread));
         end
      end
   endtask

   initial begin
      cal_model             = '0;
      cal_model.status      = ST_IDLE;
      cal_cfg.range_shift   = 2'd0;
      cal_cfg.limit         = LIMIT_RESET;
      cal_cfg.target        = TARGET_RESET;
      reset            <= 1'b1;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.op      <= OP_START;
      req_chan.accel_x <= '0;
      req_chan.accel_y <= '0;
      req_chan.accel_z <= '0;
      req_chan.gyro_x  <= '0;
      req_chan.gyro_y  <= '0;
      req_chan.gyro_z  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sample_while_idle();
      test_reading_extremes();
      test_exact_level();
      test_zero_limit();
      test_zero_target();
      test_limit_lowered();
      test_random_runs(0, 0, 355);
      test_random_runs(57, 0, 355);
      test_random_runs(0, 57, 355);
      test_random_runs(17, 17, 355);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sensor_offset_autocalibration_core.f
rtl/core/soac_pkg.sv
rtl/core/soac_req_if.sv
rtl/core/soac_rsp_if.sv
rtl/core/soac_step.sv
rtl/core/sensor_offset_autocalibration_core.sv
tb/tb_sensor_offset_autocalibration_core.sv
